// ===== hw/rtl/stwp_pkg.sv =====
// ----------------------------------------------------------------------------
// stwp_pkg
// Shared widths and codes for the sleep timer wakeup pool: stream word
// layout, result kinds, tick summary actions and input operations.
// ----------------------------------------------------------------------------
package stwp_pkg;

    // fixed field widths of the stream words
    localparam int TICK_W      = 32;
    localparam int TID_W       = 8;
    localparam int DELAY_W     = 31;
    localparam int KIND_W      = 2;
    localparam int ACTION_W    = 2;
    localparam int IN_TDATA_W  = 48;   // 41 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 16;   // 11 bits of fields, padded to bytes

    // input operations (slave tuser)
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result kinds (master tuser)
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WOKEN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // tick summary actions
    localparam logic [ACTION_W-1:0] ACTION_YIELD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_DISABLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_NONE    = 2'd2;

    typedef logic [TICK_W-1:0] t_tick;

endpackage

// ===== hw/rtl/sleep_timer_wakeup_pool_unit.sv =====
// ----------------------------------------------------------------------------
// sleep_timer_wakeup_pool_unit
// Pool of sleeping thread ids with wrap-aware deadlines, held in one
// synchronous memory and walked by a small slot sequencer.
// ----------------------------------------------------------------------------
// A sleep word stores its thread id in the lowest free slot with deadline
// tick_count + delay and returns one acknowledge word (accepted = 0 when the
// pool is full). A tick word bumps tick_count, walks the slots from 0 up,
// returns one woken word for every slot whose deadline has been reached and
// frees it, then ends with a summary word (disable timer, nothing, or yield)
// marked by tlast. Occupancy lives in reset-cleared flops; ids and deadlines
// live in a single-port memory with a registered read. A sleep word looks
// at one slot per cycle until a free one is found; a tick word passes each
// occupied slot through a memory read state and a compare state, the latter
// waiting on a full output register when the slot is due. The input takes a
// new word as soon as the sequencer is back in idle, even while the last
// result still waits in the output register. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module sleep_timer_wakeup_pool_unit
    import stwp_pkg::*;
#(
    parameter int SLOTS          = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // thread_id[7:0], delay[38:8],
                                                   // machine_idle[39], future_pending[40]
    input  logic                   s_axis_tuser,   // op: 0 sleep, 1 tick
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // woken_id[7:0], accepted[8],
                                                   // action[10:9]
    output logic [KIND_W-1:0]      m_axis_tuser,   // kind
    output logic                   m_axis_tlast    // last word of this request
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int MEM_W  = TICK_W + THREAD_ID_BITS;
    localparam int WIDE_W = (THREAD_ID_BITS > TID_W) ? THREAD_ID_BITS : TID_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request word
    localparam logic [2:0] S_FIND = 3'd1;   // sleep: look for the lowest free slot
    localparam logic [2:0] S_RD   = 3'd2;   // tick: issue read of an occupied slot
    localparam logic [2:0] S_EV   = 3'd3;   // tick: compare deadline, maybe emit
    localparam logic [2:0] S_SUM  = 3'd4;   // tick: emit the summary word

    // control state
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [SLOTS-1:0] r_valid, n_valid;
    t_tick            r_tick, n_tick;
    logic             r_woke, n_woke;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;

    // latched request fields
    logic [TID_W-1:0]   r_tid, n_tid;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic               r_idle, n_idle;
    logic               r_future, n_future;

    // output register payload
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [TID_W-1:0]    r_out_woken, n_out_woken;
    logic                r_out_acc, n_out_acc;
    logic [ACTION_W-1:0] r_out_action, n_out_action;
    logic                r_out_last, n_out_last;

    // slot memory: {thread id, deadline}
    logic [MEM_W-1:0] r_mem [SLOTS];
    logic [MEM_W-1:0] r_rd_data;
    logic             mem_we;
    logic             mem_re;
    logic [MEM_W-1:0] mem_wdata;

    logic                      in_acc;
    logic                      out_free;
    t_tick                     rd_deadline;
    logic [THREAD_ID_BITS-1:0] rd_thread;
    logic [WIDE_W-1:0]         rd_thread_wide;
    logic [WIDE_W-1:0]         wr_thread_wide;
    t_tick                     due_diff;
    logic                      slot_due;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    // output register can take a word this cycle
    assign out_free      = !r_out_valid || m_axis_tready;

    assign rd_deadline    = r_rd_data[TICK_W-1:0];
    assign rd_thread      = r_rd_data[MEM_W-1:TICK_W];
    assign rd_thread_wide = WIDE_W'(rd_thread);
    assign wr_thread_wide = WIDE_W'(r_tid);
    // wrap-aware: due once tick - deadline is non-negative as a signed value
    assign due_diff       = r_tick - rd_deadline;
    assign slot_due       = !due_diff[TICK_W-1];

    assign mem_wdata = {wr_thread_wide[THREAD_ID_BITS-1:0],
                        r_tick + TICK_W'(r_delay)};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_tick       = r_tick;
        n_woke       = r_woke;
        n_empty      = r_empty;
        n_tid        = r_tid;
        n_delay      = r_delay;
        n_idle       = r_idle;
        n_future     = r_future;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_woken  = r_out_woken;
        n_out_acc    = r_out_acc;
        n_out_action = r_out_action;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_tid    = s_axis_tdata[7:0];
                    n_delay  = s_axis_tdata[38:8];
                    n_idle   = s_axis_tdata[39];
                    n_future = s_axis_tdata[40];
                    n_idx    = '0;
                    if (s_axis_tuser == OP_TICK) begin
                        n_tick  = r_tick + TICK_W'(1);
                        n_woke  = 1'b0;
                        n_empty = 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (!r_valid[r_idx] || r_idx == LAST_IDX) begin
                    // free slot found, or pool full at the top slot
                    if (out_free) begin
                        if (!r_valid[r_idx]) begin
                            mem_we         = 1'b1;
                            n_valid[r_idx] = 1'b1;
                        end
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_ACK;
                        n_out_woken  = '0;
                        n_out_acc    = !r_valid[r_idx];
                        n_out_action = ACTION_YIELD;
                        n_out_last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_RD: begin
                if (r_valid[r_idx]) begin
                    mem_re  = 1'b1;
                    n_state = S_EV;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_SUM;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EV: begin
                if (!slot_due || out_free) begin
                    if (slot_due) begin
                        n_valid[r_idx] = 1'b0;
                        n_woke         = 1'b1;
                        n_out_valid    = 1'b1;
                        n_out_kind     = KIND_WOKEN;
                        n_out_woken    = rd_thread_wide[TID_W-1:0];
                        n_out_acc      = 1'b0;
                        n_out_action   = ACTION_YIELD;
                        n_out_last     = 1'b0;
                    end else begin
                        n_empty = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_SUM;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SUMMARY;
                    n_out_woken = '0;
                    n_out_acc   = 1'b0;
                    if (r_idle && !r_woke && r_empty) begin
                        n_out_action = r_future ? ACTION_NONE : ACTION_DISABLE;
                    end else begin
                        n_out_action = ACTION_YIELD;
                    end
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_tick      <= '0;
            r_woke      <= 1'b0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_tick      <= n_tick;
            r_woke      <= n_woke;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tid        <= n_tid;
        r_delay      <= n_delay;
        r_idle       <= n_idle;
        r_future     <= n_future;
        r_out_kind   <= n_out_kind;
        r_out_woken  <= n_out_woken;
        r_out_acc    <= n_out_acc;
        r_out_action <= n_out_action;
        r_out_last   <= n_out_last;
    end

    // slot memory, one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b0, r_out_action, r_out_acc, r_out_woken};

    // a compare cycle always looks at an occupied slot
    a_ev_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> r_valid[r_idx])
        else $error("deadline compare on a free slot");

    // a tick advances the tick count by exactly one and restarts the walk
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == OP_TICK) |=>
            (r_tick == $past(r_tick) + TICK_W'(1)) && r_state == S_RD && r_idx == '0)
        else $error("tick did not step the count or restart the walk");

    // a woken word never closes a request
    a_woken_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_WOKEN) |-> !r_out_last)
        else $error("woken word marked as last");

    // a sleep never touches the tick count
    a_sleep_keeps_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |=> $stable(r_tick))
        else $error("tick count changed during a sleep request");

endmodule
